// ===== rtl/arpgw_pkg.sv =====
// Shared types and constants for the ARP gateway resolver.
// Holds frame offsets, protocol codes, result and status structs.
// No dependencies.
package arpgw_pkg;

	localparam int CNT_W_DEF = 32;
	localparam int REQ_LEN   = 42;

	localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  BCAST_BYTE    = 8'hFF;
	localparam logic [15:0] ARP_HTYPE_ETH = 16'h0001;
	localparam logic [7:0]  ARP_HLEN      = 8'd6;
	localparam logic [7:0]  ARP_PLEN      = 8'd4;
	localparam logic [15:0] ARP_OP_REQ    = 16'h0001;
	localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;

	// byte offsets within a received frame
	localparam logic [5:0] POS_TYPE_HI  = 6'd12;
	localparam logic [5:0] POS_TYPE_LO  = 6'd13;
	localparam logic [5:0] POS_OP_HI    = 6'd20;
	localparam logic [5:0] POS_OP_LO    = 6'd21;
	localparam logic [5:0] POS_SMAC     = 6'd22;
	localparam logic [5:0] POS_SIP      = 6'd28;
	localparam logic [5:0] POS_ARP_LAST = 6'd41;
	localparam logic [5:0] POS_MAX      = 6'd63;

	localparam logic [31:0] OWN_IP_RST = 32'h0A00_020F;
	localparam logic [31:0] GW_IP_RST  = 32'h0A00_0202;

	typedef enum logic [1:0] {
		REG_OWN_IP,
		REG_GATEWAY_IP,
		REG_OWN_MAC,
		REG_NIC_PRESENT
	} reg_idx_t;

	typedef enum logic [2:0] {
		CLS_SHORT,
		CLS_ARP_OK,
		CLS_ARP_IGN,
		CLS_OTHER,
		CLS_NOT_SENT
	} frame_class_t;

	typedef enum logic {
		KIND_TX,
		KIND_STATUS
	} kind_t;

	typedef struct packed {
		logic        resolved;
		logic [47:0] mac;
		logic [31:0] frames;
		logic [31:0] others;
		logic [31:0] replies;
		logic [31:0] requests;
	} stat_t;

	typedef struct packed {
		logic       busy;
		logic [7:0] data;
		logic       last;
	} tx_beat_t;

	typedef struct packed {
		kind_t        kind;
		logic [7:0]   tx_byte;
		logic         tx_end;
		frame_class_t cls;
		stat_t        stat;
	} result_t;

endpackage

// ===== rtl/arpgw_rx_parser.sv =====
// Receive parser, frame classifier and status counters.
// Depends on arpgw_pkg.
module arpgw_rx_parser import arpgw_pkg::*; #(
	parameter int COUNTER_WIDTH = CNT_W_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         rx_fire,
	input  logic         req_fire,
	input  logic [7:0]   rx_byte,
	input  logic         rx_last,
	input  logic [31:0]  gateway_ip,
	output stat_t        stat,
	output frame_class_t frame_class
);

	localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

	logic [5:0]               pos_q, pos_n;
	logic [15:0]              type_q, type_n;
	logic [15:0]              opcode_q, opcode_n;
	logic [47:0]              smac_q, smac_n;
	logic [31:0]              sip_q, sip_n;
	logic [47:0]              learned_q, learned_n;
	logic                     resolved_q, resolved_n;
	logic [COUNTER_WIDTH-1:0] frames_q, frames_n;
	logic [COUNTER_WIDTH-1:0] others_q, others_n;
	logic [COUNTER_WIDTH-1:0] replies_q, replies_n;
	logic [COUNTER_WIDTH-1:0] requests_q, requests_n;

	always_comb begin
		pos_n       = pos_q;
		type_n      = type_q;
		opcode_n    = opcode_q;
		smac_n      = smac_q;
		sip_n       = sip_q;
		learned_n   = learned_q;
		resolved_n  = resolved_q;
		frames_n    = frames_q;
		others_n    = others_q;
		replies_n   = replies_q;
		requests_n  = requests_q;
		frame_class = CLS_SHORT;

		if (req_fire) begin
			requests_n = requests_q + CNT_ONE;
		end

		if (rx_fire) begin
			if (pos_q == POS_TYPE_HI) type_n[15:8] = rx_byte;
			if (pos_q == POS_TYPE_LO) type_n[7:0] = rx_byte;
			if (pos_q == POS_OP_HI) opcode_n[15:8] = rx_byte;
			if (pos_q == POS_OP_LO) opcode_n[7:0] = rx_byte;
			for (int i = 0; i < 6; i++) begin
				if (pos_q == POS_SMAC + 6'(i)) smac_n[47-8*i -: 8] = rx_byte;
			end
			for (int i = 0; i < 4; i++) begin
				if (pos_q == POS_SIP + 6'(i)) sip_n[31-8*i -: 8] = rx_byte;
			end

			if (rx_last) begin
				// classify on the position of the last byte, then restart
				pos_n    = '0;
				frames_n = frames_q + CNT_ONE;
				if (pos_q < POS_TYPE_LO) begin
					frame_class = CLS_SHORT;
				end else if (type_n != ETH_TYPE_ARP) begin
					others_n    = others_q + CNT_ONE;
					frame_class = CLS_OTHER;
				end else if (pos_q >= POS_ARP_LAST && opcode_n == ARP_OP_REPLY &&
						sip_n == gateway_ip) begin
					learned_n   = smac_n;
					resolved_n  = 1'b1;
					replies_n   = replies_q + CNT_ONE;
					frame_class = CLS_ARP_OK;
				end else begin
					frame_class = CLS_ARP_IGN;
				end
			end else if (pos_q != POS_MAX) begin
				pos_n = pos_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			type_q     <= '0;
			opcode_q   <= '0;
			smac_q     <= '0;
			sip_q      <= '0;
			learned_q  <= '0;
			resolved_q <= 1'b0;
			frames_q   <= '0;
			others_q   <= '0;
			replies_q  <= '0;
			requests_q <= '0;
		end else begin
			pos_q      <= pos_n;
			type_q     <= type_n;
			opcode_q   <= opcode_n;
			smac_q     <= smac_n;
			sip_q      <= sip_n;
			learned_q  <= learned_n;
			resolved_q <= resolved_n;
			frames_q   <= frames_n;
			others_q   <= others_n;
			replies_q  <= replies_n;
			requests_q <= requests_n;
		end
	end

	// status reflects this cycle's update
	assign stat.resolved = resolved_n;
	assign stat.mac      = learned_n;
	assign stat.frames   = 32'(frames_n);
	assign stat.others   = 32'(others_n);
	assign stat.replies  = 32'(replies_n);
	assign stat.requests = 32'(requests_n);

endmodule

// ===== rtl/arpgw_tx_gen.sv =====
// ARP request sequencer: steps through the 42 bytes of a broadcast request.
// Depends on arpgw_pkg.
module arpgw_tx_gen import arpgw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        advance,
	input  logic [47:0] own_mac,
	input  logic [31:0] own_ip,
	input  logic [31:0] gateway_ip,
	output tx_beat_t    beat
);

	localparam logic [5:0] LAST_POS = 6'(REQ_LEN - 1);

	logic                    busy_q;
	logic [5:0]              pos_q;
	logic [5:0]              byte_idx;
	logic [8*REQ_LEN-1:0]    frame_vec;

	// request frame, first wire byte in the top bits
	assign frame_vec = {
		{6{BCAST_BYTE}}, own_mac, ETH_TYPE_ARP,
		ARP_HTYPE_ETH, ETH_TYPE_IPV4, ARP_HLEN, ARP_PLEN, ARP_OP_REQ,
		own_mac, own_ip, 48'h0, gateway_ip
	};

	assign byte_idx = LAST_POS - pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (busy_q && advance) begin
			if (pos_q == LAST_POS) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 6'd1;
			end
		end
	end

	assign beat.busy = busy_q;
	assign beat.data = frame_vec[{byte_idx, 3'b000} +: 8];
	assign beat.last = (pos_q == LAST_POS);

endmodule

// ===== rtl/arpgw_out_fifo.sv =====
// Two-entry result queue between the core and the output channel.
// Depends on arpgw_pkg.
module arpgw_out_fifo import arpgw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    full,
	output logic    not_empty,
	output result_t head
);

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

endmodule

// ===== rtl/arp_gateway_resolver.sv =====
// ARP gateway resolver: received Ethernet bytes enter at one per cycle while
// in_ready is high, pass one input register and are parsed from it; a frame's
// last byte yields one status result. A send command emits a 42-byte broadcast
// ARP request, one byte per cycle while the queue has room, during which the
// input register holds; with the interface absent it yields a not-sent status
// result instead. Results go through a two-entry queue, so input keeps flowing
// while one result waits at the output. There is no clearing pass after reset.
// Depends on arpgw_pkg, arpgw_rx_parser, arpgw_tx_gen and arpgw_out_fifo.
module arp_gateway_resolver import arpgw_pkg::*; #(
	parameter int COUNTER_WIDTH = CNT_W_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	input  logic        rx_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic        tx_end,
	output logic [2:0]  frame_class,
	output logic        gateway_known,
	output logic [47:0] gw_mac,
	output logic [31:0] frames_seen,
	output logic [31:0] other_frames,
	output logic [31:0] arp_replies,
	output logic [31:0] arp_requests
);

	logic [31:0]  own_ip_q;
	logic [31:0]  gateway_ip_q;
	logic [47:0]  own_mac_q;
	logic         nic_present_q;

	logic         valid_s1;
	logic         command_s1;
	logic [7:0]   rx_byte_s1;
	logic         rx_last_s1;

	logic         fifo_full;
	logic         fifo_pop;
	logic         room;
	logic         tx_push;
	logic         s1_fire;
	logic         rx_fire;
	logic         req_fire;
	logic         push;
	result_t      push_data;
	result_t      head;
	stat_t        stat;
	frame_class_t rx_class;
	tx_beat_t     beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q      <= OWN_IP_RST;
			gateway_ip_q  <= GW_IP_RST;
			own_mac_q     <= '0;
			nic_present_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OWN_IP:      own_ip_q <= cfg_data[31:0];
				REG_GATEWAY_IP:  gateway_ip_q <= cfg_data[31:0];
				REG_OWN_MAC:     own_mac_q <= cfg_data;
				REG_NIC_PRESENT: nic_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign fifo_pop = out_valid && out_ready;
	assign room     = !fifo_full || fifo_pop;
	assign tx_push  = beat.busy && room;
	// hold the input stage while a request is going out
	assign s1_fire  = valid_s1 && !beat.busy && room;
	assign rx_fire  = s1_fire && !command_s1;
	assign req_fire = s1_fire && command_s1 && nic_present_q;
	assign in_ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1 <= command;
			rx_byte_s1 <= rx_byte;
			rx_last_s1 <= rx_last;
		end
	end

	arpgw_rx_parser #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_fire     (rx_fire),
		.req_fire    (req_fire),
		.rx_byte     (rx_byte_s1),
		.rx_last     (rx_last_s1),
		.gateway_ip  (gateway_ip_q),
		.stat        (stat),
		.frame_class (rx_class)
	);

	arpgw_tx_gen u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (req_fire),
		.advance    (tx_push),
		.own_mac    (own_mac_q),
		.own_ip     (own_ip_q),
		.gateway_ip (gateway_ip_q),
		.beat       (beat)
	);

	always_comb begin
		push_data = '0;
		push      = 1'b0;
		if (tx_push) begin
			push              = 1'b1;
			push_data.kind    = KIND_TX;
			push_data.tx_byte = beat.data;
			push_data.tx_end  = beat.last;
		end else if (s1_fire) begin
			push_data.kind = KIND_STATUS;
			push_data.stat = stat;
			if (command_s1) begin
				push          = !nic_present_q;
				push_data.cls = CLS_NOT_SENT;
			end else begin
				push          = rx_last_s1;
				push_data.cls = rx_class;
			end
		end
	end

	arpgw_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (fifo_pop),
		.full      (fifo_full),
		.not_empty (out_valid),
		.head      (head)
	);

	assign kind          = head.kind;
	assign tx_byte       = head.tx_byte;
	assign tx_end        = head.tx_end;
	assign frame_class   = head.cls;
	assign gateway_known = head.stat.resolved;
	assign gw_mac        = head.stat.mac;
	assign frames_seen   = head.stat.frames;
	assign other_frames  = head.stat.others;
	assign arp_replies   = head.stat.replies;
	assign arp_requests  = head.stat.requests;

endmodule

// ===== rtl/arpgw_checker.sv =====
// Port-level checks for the ARP gateway resolver, bound to the top level.
// Depends on arpgw_pkg and arp_gateway_resolver.
module arpgw_checker import arpgw_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [7:0]  tx_byte,
	input logic        tx_end,
	input logic [2:0]  frame_class,
	input logic        gateway_known,
	input logic [31:0] frames_seen,
	input logic [31:0] arp_replies
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(tx_byte)
			&& $stable(frame_class) && $stable(frames_seen))
		else $error("stalled result changed");

	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_TX |-> frame_class == 3'(CLS_SHORT) && !gateway_known
			&& frames_seen == '0 && arp_replies == '0)
		else $error("transmit transfer carries status bits");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS |-> tx_byte == '0 && !tx_end)
		else $error("status transfer carries transmit bits");

	a_accept_resolves: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_STATUS && frame_class == 3'(CLS_ARP_OK)
			|-> gateway_known && arp_replies != '0)
		else $error("accepted reply without resolved state");

endmodule

bind arp_gateway_resolver arpgw_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.kind          (kind),
	.tx_byte       (tx_byte),
	.tx_end        (tx_end),
	.frame_class   (frame_class),
	.gateway_known (gateway_known),
	.frames_seen   (frames_seen),
	.arp_replies   (arp_replies)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for arp_gateway_resolver: request emission, frame parsing and status.
// Depends on arpgw_pkg and the arp_gateway_resolver RTL; predicts every result in SystemVerilog.
module tb_top;
	import arpgw_pkg::*;

	localparam int RANDOM_ITEMS = 220;
	localparam int SETTLE_CYCLES = 10;
	localparam int STALL_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        command = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        rx_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        tx_end;
	logic [2:0]  frame_class;
	logic        gateway_known;
	logic [47:0] gw_mac;
	logic [31:0] frames_seen;
	logic [31:0] other_frames;
	logic [31:0] arp_replies;
	logic [31:0] arp_requests;

	// register copies
	logic [31:0] own_ip_sh;
	logic [31:0] gateway_ip_sh;
	logic [47:0] own_mac_sh;
	logic        nic_sh;

	// parser and status copies
	logic [5:0]  rx_pos;
	logic [15:0] eth_type;
	logic [15:0] arp_op;
	logic [47:0] sender_mac;
	logic [31:0] sender_ip;
	logic [47:0] learned_mac;
	logic        resolved;
	logic [31:0] frame_cnt;
	logic [31:0] other_cnt;
	logic [31:0] reply_cnt;
	logic [31:0] request_cnt;

	result_t     awaited_results[$];
	result_t     head;
	logic [7:0]  frame_bytes[$];
	int          mismatches = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int          stall_cycles = 0;

	arp_gateway_resolver i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.rx_byte       (rx_byte),
		.rx_last       (rx_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.tx_byte       (tx_byte),
		.tx_end        (tx_end),
		.frame_class   (frame_class),
		.gateway_known (gateway_known),
		.gw_mac        (gw_mac),
		.frames_seen   (frames_seen),
		.other_frames  (other_frames),
		.arp_replies   (arp_replies),
		.arp_requests  (arp_requests)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("** arp_gateway_resolver: FAILED **");
		$finish;
	end

	task automatic reset_shadow();
		own_ip_sh = OWN_IP_RST;
		gateway_ip_sh = GW_IP_RST;
		own_mac_sh = '0;
		nic_sh = 1'b1;
		rx_pos = '0;
		eth_type = '0;
		arp_op = '0;
		sender_mac = '0;
		sender_ip = '0;
		learned_mac = '0;
		resolved = 1'b0;
		frame_cnt = '0;
		other_cnt = '0;
		reply_cnt = '0;
		request_cnt = '0;
	endtask

	function automatic logic [7:0] request_byte(int p);
		if (p < 6) return BCAST_BYTE;
		if (p < 12) return own_mac_sh[8*(11-p) +: 8];
		case (p)
			12: return ETH_TYPE_ARP[15:8];
			13: return ETH_TYPE_ARP[7:0];
			14: return ARP_HTYPE_ETH[15:8];
			15: return ARP_HTYPE_ETH[7:0];
			16: return ETH_TYPE_IPV4[15:8];
			17: return ETH_TYPE_IPV4[7:0];
			18: return ARP_HLEN;
			19: return ARP_PLEN;
			20: return ARP_OP_REQ[15:8];
			21: return ARP_OP_REQ[7:0];
			default: ;
		endcase
		if (p < 28) return own_mac_sh[8*(27-p) +: 8];
		if (p < 32) return own_ip_sh[8*(31-p) +: 8];
		if (p < 38) return 8'h00;
		return gateway_ip_sh[8*(41-p) +: 8];
	endfunction

	function automatic result_t status_result(frame_class_t c);
		result_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.cls = c;
		r.stat.resolved = resolved;
		r.stat.mac = learned_mac;
		r.stat.frames = frame_cnt;
		r.stat.others = other_cnt;
		r.stat.replies = reply_cnt;
		r.stat.requests = request_cnt;
		return r;
	endfunction

	// Queue the results that one accepted transfer must produce.
	task automatic predict_arp_results(logic cmd, logic [7:0] b, logic last);
		result_t      r;
		logic [5:0]   p;
		frame_class_t c;
		if (cmd) begin
			if (!nic_sh) begin
				awaited_results.push_back(status_result(CLS_NOT_SENT));
				return;
			end
			request_cnt = request_cnt + 32'd1;
			for (int i = 0; i < REQ_LEN; i++) begin
				r = '0;
				r.kind = KIND_TX;
				r.tx_byte = request_byte(i);
				r.tx_end = (i == REQ_LEN - 1);
				awaited_results.push_back(r);
			end
			return;
		end
		p = rx_pos;
		if (p == POS_TYPE_HI) eth_type[15:8] = b;
		else if (p == POS_TYPE_LO) eth_type[7:0] = b;
		else if (p == POS_OP_HI) arp_op[15:8] = b;
		else if (p == POS_OP_LO) arp_op[7:0] = b;
		else if (p >= POS_SMAC && p < POS_SIP) sender_mac[8*(27-int'(p)) +: 8] = b;
		else if (p >= POS_SIP && p < POS_SIP + 4) sender_ip[8*(31-int'(p)) +: 8] = b;
		if (rx_pos < POS_MAX) rx_pos = rx_pos + 6'd1;
		if (!last) return;
		rx_pos = '0;
		frame_cnt = frame_cnt + 32'd1;
		if (p < POS_TYPE_LO) begin
			c = CLS_SHORT;
		end else if (eth_type != ETH_TYPE_ARP) begin
			other_cnt = other_cnt + 32'd1;
			c = CLS_OTHER;
		end else if (p >= POS_ARP_LAST && arp_op == ARP_OP_REPLY && sender_ip == gateway_ip_sh) begin
			learned_mac = sender_mac;
			resolved = 1'b1;
			reply_cnt = reply_cnt + 32'd1;
			c = CLS_ARP_OK;
		end else begin
			c = CLS_ARP_IGN;
		end
		awaited_results.push_back(status_result(c));
	endtask

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: %s mismatch: got %0h, expected %0h", $time, field, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing awaited", 64'({kind, tx_byte}), 64'd0);
			end else begin
				head = awaited_results.pop_front();
				if (kind !== head.kind) report_mismatch("kind", kind, head.kind);
				if (tx_byte !== head.tx_byte) report_mismatch("tx_byte", tx_byte, head.tx_byte);
				if (tx_end !== head.tx_end) report_mismatch("tx_end", tx_end, head.tx_end);
				if (frame_class !== head.cls) report_mismatch("frame_class", frame_class, head.cls);
				if (gateway_known !== head.stat.resolved)
					report_mismatch("gateway_known", gateway_known, head.stat.resolved);
				if (gw_mac !== head.stat.mac) report_mismatch("gw_mac", gw_mac, head.stat.mac);
				if (frames_seen !== head.stat.frames)
					report_mismatch("frames_seen", frames_seen, head.stat.frames);
				if (other_frames !== head.stat.others)
					report_mismatch("other_frames", other_frames, head.stat.others);
				if (arp_replies !== head.stat.replies)
					report_mismatch("arp_replies", arp_replies, head.stat.replies);
				if (arp_requests !== head.stat.requests)
					report_mismatch("arp_requests", arp_requests, head.stat.requests);
			end
		end
	end

	// Result side: random hold-off per transfer, plus a long stall on request.
	initial begin : result_sink
		int gap;
		int hold;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (stall_cycles != 0) begin
				hold = stall_cycles;
				stall_cycles = 0;
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			gap = rx_idle_on ? $urandom_range(0, 13) : 0;
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one item and hold it until the transfer; valid stays high afterwards.
	task automatic send_item(logic cmd, logic [7:0] b, logic last);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		rx_byte <= b;
		rx_last <= last;
		do @(posedge clk); while (!in_ready);
		predict_arp_results(cmd, b, last);
	endtask

	// Send frame_bytes, optionally with a request command slipped in before byte req_at.
	task automatic emit_frame(int req_at, inout int count);
		for (int i = 0; i < frame_bytes.size(); i++) begin
			if (i == req_at) begin
				send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				count++;
			end
			send_item(1'b0, frame_bytes[i], i == frame_bytes.size() - 1);
			if (i < POS_MAX || i == frame_bytes.size() - 1) count++;
		end
	endtask

	// Drop valid, wait for every awaited result, then let the pipeline settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [47:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_OWN_IP:      own_ip_sh = data[31:0];
			REG_GATEWAY_IP:  gateway_ip_sh = data[31:0];
			REG_OWN_MAC:     own_mac_sh = data;
			REG_NIC_PRESENT: nic_sh = data[0];
			default: ;
		endcase
	endtask

	function automatic logic [47:0] pick_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	task automatic randomize_registers();
		logic [47:0] v;
		write_reg(REG_OWN_IP, pick_value());
		v = pick_value();
		if ($urandom_range(0, 2) == 0) v[31:0] = GW_IP_RST;
		write_reg(REG_GATEWAY_IP, v);
		write_reg(REG_OWN_MAC, pick_value());
		v = pick_value();
		v[0] = ($urandom_range(0, 4) != 0);
		write_reg(REG_NIC_PRESENT, v);
	endtask

	task automatic fill_random(int len);
		frame_bytes.delete();
		for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic put_bytes(int at, int nbytes, logic [63:0] v);
		for (int i = 0; i < nbytes; i++)
			if (at + i < frame_bytes.size()) frame_bytes[at + i] = v[8*(nbytes-1-i) +: 8];
	endtask

	task automatic test_request_registers();
		int n;
		n = 0;
		// reset values first, then every register at both extremes
		send_item(1'b1, 8'hFF, 1'b1);
		drain_results();
		write_reg(REG_OWN_IP, '1);
		write_reg(REG_GATEWAY_IP, '0);
		write_reg(REG_OWN_MAC, '1);
		send_item(1'b1, 8'h00, 1'b0);
		drain_results();
		write_reg(REG_OWN_IP, 48'hA5A5_0000_0000);
		write_reg(REG_GATEWAY_IP, '1);
		write_reg(REG_OWN_MAC, 48'h0123_4567_89AB);
		send_item(1'b1, 8'h5A, 1'b1);
		drain_results();
		// upper bits set, bit 0 clear: interface absent
		write_reg(REG_NIC_PRESENT, 48'hFFFF_FFFF_FFFE);
		send_item(1'b1, 8'hFF, 1'b0);
		drain_results();
		write_reg(REG_NIC_PRESENT, 48'h0000_0000_0001);
		write_reg(REG_GATEWAY_IP, GW_IP_RST);
		// one-byte frame, then a minimal ARP-type frame with a request in its middle
		frame_bytes.delete();
		frame_bytes.push_back(8'hFF);
		emit_frame(-1, n);
		fill_random(14);
		for (int i = 0; i < 14; i++) frame_bytes[i] = 8'h00;
		put_bytes(POS_TYPE_HI, 2, ETH_TYPE_ARP);
		emit_frame(5, n);
		drain_results();
	endtask

	task automatic test_random_traffic();
		int sent;
		int frames;
		int flavor;
		int len;
		int r;
		int req_at;
		sent = 0;
		frames = 0;
		while (sent < RANDOM_ITEMS) begin
			if (frames % 6 == 0) begin
				drain_results();
				randomize_registers();
				tx_idle_on = ($urandom_range(0, 3) != 0);
				rx_idle_on = ($urandom_range(0, 3) != 0);
			end
			flavor = $urandom_range(0, 99);
			if (flavor < 45) begin
				// gateway reply, mostly well-formed
				r = $urandom_range(0, 9);
				len = (r < 6) ? 42 : (r < 8) ? $urandom_range(43, 72) :
					(r == 8) ? 41 : $urandom_range(30, 40);
				fill_random(len);
				put_bytes(POS_TYPE_HI, 2, ETH_TYPE_ARP);
				put_bytes(POS_OP_HI, 2, ARP_OP_REPLY);
				if ($urandom_range(0, 9) != 0) put_bytes(POS_SIP, 4, gateway_ip_sh);
			end else if (flavor < 60) begin
				fill_random(42);
				put_bytes(POS_TYPE_HI, 2, ETH_TYPE_ARP);
				if ($urandom_range(0, 1) == 0) put_bytes(POS_OP_HI, 2, ARP_OP_REQ);
				put_bytes(POS_SIP, 4, gateway_ip_sh);
			end else if (flavor < 75) begin
				fill_random($urandom_range(14, 40));
				if ($urandom_range(0, 1) == 0) put_bytes(POS_TYPE_HI, 2, ETH_TYPE_IPV4);
			end else if (flavor < 90) begin
				fill_random($urandom_range(1, 13));
			end else begin
				fill_random($urandom_range(1, 64));
			end
			req_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, frame_bytes.size() - 1) : -1;
			emit_frame(req_at, sent);
			if ($urandom_range(0, 11) == 0) begin
				send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				sent++;
			end
			frames++;
		end
		drain_results();
	endtask

	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_reg(REG_NIC_PRESENT, 48'h1);
		stall_cycles = STALL_CYCLES;
		// keep offering short frames so the result queue fills and input stalls
		for (int i = 0; i < 16; i++) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
		send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		for (int i = 0; i < 4; i++) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
		drain_results();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		reset_shadow();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_request_registers();
		test_random_traffic();
		test_backpressure();
		drain_results();
		if (awaited_results.size() != 0)
			report_mismatch("results never delivered", 64'(awaited_results.size()), 64'd0);
		if (mismatches == 0) begin
			$display("** arp_gateway_resolver: PASSED **");
		end else begin
			$display("** arp_gateway_resolver: FAILED **");
		end
		$finish;
	end

endmodule
